FILE: design/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants and types for the signed decimal formatter: field widths,
// register indexes, character codes and the packed decimal digit type.
// ----------------------------------------------------------------------------
package sdf_pkg;

    // Input value and decimal digit geometry.
    localparam int VAL_W      = 32;
    localparam int NDIG       = 10;
    localparam int DIG_W      = 4;
    localparam int BCD_W      = NDIG * DIG_W;
    localparam int STEP_W     = $clog2(VAL_W + 1);
    localparam int NDIG_CNT_W = $clog2(NDIG + 1);
    localparam int DIG_IDX_W  = $clog2(NDIG);

    // Output character width.
    localparam int CHAR_W = 8;

    // Formatting limits.
    localparam int MAX_WIDTH     = 48;
    localparam int MAX_PRECISION = 32;

    // Longest possible text: the width, or sign plus precision plus digits.
    localparam int LEN_MAX = (MAX_WIDTH > MAX_PRECISION + NDIG + 1) ?
                             MAX_WIDTH : (MAX_PRECISION + NDIG + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Length counters also hold a raw register value for saturation compares.
    localparam int CNT_W = ($clog2(LEN_MAX + 1) > CFG_DATA_W) ?
                           $clog2(LEN_MAX + 1) : CFG_DATA_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION_GIVEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_PLUS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIGN      = 3'd6;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef logic [NDIG-1:0][DIG_W-1:0] t_bcd;
    typedef logic [CNT_W-1:0]           t_len;

endpackage

FILE: design/signed_decimal_formatter_top.sv
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top
// Formats one 32-bit signed integer per item as printf "%d" text and sends it
// out one ASCII character per item, with o_last_char on the final character.
// Field width, precision and the left-justify, zero-fill, plus and space flags
// come from seven registers written through the plain write port; the user
// must write them only while the block is idle, which the block itself does
// not enforce. The most negative value prints exactly. A zero printed with a
// given precision of zero has no digits, and a value whose text is empty
// produces no output items at all. After an item is accepted, the magnitude
// goes through a bit-serial binary to decimal converter that shifts one bit
// per cycle, and the sequencer waits in its conversion state until it
// finishes; the plan and layout states then lay out the text (digit count,
// sign, precision zeros, padding); then the text is emitted at one character
// per cycle while the output does not stall, up to 48 characters. The next
// item is taken in the cycle after the last character enters the output
// register, even if that character is still waiting to be taken.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_top import sdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_valid,
    input  logic [VAL_W-1:0]      i_value,
    output logic                  o_stall,
    // Output channel.
    output logic                  o_valid,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic                  o_last_char,
    input  logic                  i_stall,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_PLAN   = 3'd2;
    localparam logic [2:0] ST_LAYOUT = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_field_width;
    logic [CFG_DATA_W-1:0] r_min_digits;
    logic                  r_precision_given;
    logic                  r_left_justify;
    logic                  r_zero_fill;
    logic                  r_force_plus;
    logic                  r_space_sign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width     <= '0;
            r_min_digits      <= '0;
            r_precision_given <= 1'b0;
            r_left_justify    <= 1'b0;
            r_zero_fill       <= 1'b0;
            r_force_plus      <= 1'b0;
            r_space_sign      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIELD_WIDTH:     r_field_width     <= i_cfg_data;
                REG_MIN_DIGITS:      r_min_digits      <= i_cfg_data;
                REG_PRECISION_GIVEN: r_precision_given <= i_cfg_data[0];
                REG_LEFT_JUSTIFY:    r_left_justify    <= i_cfg_data[0];
                REG_ZERO_FILL:       r_zero_fill       <= i_cfg_data[0];
                REG_FORCE_PLUS:      r_force_plus      <= i_cfg_data[0];
                REG_SPACE_SIGN:      r_space_sign      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state.
    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_o_valid;

    // Per-item layout, held while the text is emitted.
    logic                  r_neg;
    logic [NDIG_CNT_W-1:0] r_ndig;
    t_len                  r_prec_zeros;
    logic                  r_sign_len;
    logic [CHAR_W-1:0]     r_sign_ch;
    t_len                  r_b_lead;
    t_len                  r_b_sign;
    t_len                  r_b_zero;
    t_len                  r_b_dig;
    t_len                  r_total;
    t_len                  r_pos;
    logic [DIG_IDX_W-1:0]  r_dig;
    logic [CHAR_W-1:0]     r_o_char;
    logic                  r_o_last;

    logic                  accept;
    logic [VAL_W-1:0]      mag;
    logic                  bcd_busy;
    t_bcd                  bcd;

    assign accept = i_valid && !o_stall;
    // Two's complement negation; the most negative value maps onto itself,
    // which as an unsigned magnitude is exactly right.
    assign mag = i_value[VAL_W-1] ? (VAL_W'(0) - i_value) : i_value;

    sdf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_mag   (mag),
        .o_busy  (bcd_busy),
        .o_bcd   (bcd)
    );

    // Digit count and precision zeros, evaluated in the plan cycle.
    t_len                  prec_sat;
    t_len                  min_ext;
    logic [NDIG_CNT_W-1:0] ndig_raw;
    logic [NDIG_CNT_W-1:0] ndig;
    logic                  zero_suppress;
    t_len                  prec_zeros;

    always_comb begin
        min_ext  = t_len'(r_min_digits);
        prec_sat = (min_ext > t_len'(MAX_PRECISION)) ? t_len'(MAX_PRECISION) : min_ext;
        ndig_raw = NDIG_CNT_W'(1);
        for (int i = 1; i < NDIG; i++) begin
            if (bcd[i] != '0) begin
                ndig_raw = NDIG_CNT_W'(i + 1);
            end
        end
        zero_suppress = r_precision_given && (prec_sat == '0) && (bcd == '0);
        ndig          = zero_suppress ? '0 : ndig_raw;
        prec_zeros    = (r_precision_given && (prec_sat > t_len'(ndig))) ?
                        (prec_sat - t_len'(ndig)) : '0;
    end

    // Segment boundaries, evaluated in the layout cycle. The text is leading
    // spaces, sign, fill zeros, precision zeros, digits, trailing spaces.
    t_len width_sat;
    t_len width_ext;
    t_len body;
    t_len pad;
    logic zpad;
    t_len b_lead;
    t_len b_sign;
    t_len b_zero;
    t_len b_dig;
    t_len total;

    always_comb begin
        width_ext = t_len'(r_field_width);
        width_sat = (width_ext > t_len'(MAX_WIDTH)) ? t_len'(MAX_WIDTH) : width_ext;
        body      = t_len'(r_sign_len) + r_prec_zeros + t_len'(r_ndig);
        pad       = (width_sat > body) ? (width_sat - body) : '0;
        zpad      = r_zero_fill && !r_left_justify && !r_precision_given;
        b_lead    = (!r_left_justify && !zpad) ? pad : '0;
        b_sign    = b_lead + t_len'(r_sign_len);
        b_zero    = b_sign + (zpad ? pad : '0) + r_prec_zeros;
        b_dig     = b_zero + t_len'(r_ndig);
        total     = b_dig + (r_left_justify ? pad : '0);
    end

    // Character at the current position.
    logic              advance;
    logic              is_digit;
    logic              is_last;
    logic [CHAR_W-1:0] cur_char;

    assign advance = (r_state == ST_EMIT) && (!r_o_valid || !i_stall);
    assign is_last = (r_pos == (r_total - 1'b1));

    always_comb begin
        is_digit = 1'b0;
        if (r_pos < r_b_lead) begin
            cur_char = CH_SPACE;
        end else if (r_pos < r_b_sign) begin
            cur_char = r_sign_ch;
        end else if (r_pos < r_b_zero) begin
            cur_char = CH_ZERO;
        end else if (r_pos < r_b_dig) begin
            cur_char = CH_ZERO + CHAR_W'(bcd[r_dig]);
            is_digit = 1'b1;
        end else begin
            cur_char = CH_SPACE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!bcd_busy) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_state = ST_LAYOUT;
            end
            ST_LAYOUT: begin
                // Empty text: nothing to send.
                n_state = (total == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (advance && is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[VAL_W-1];
        end
        if (r_state == ST_PLAN) begin
            r_ndig       <= ndig;
            r_prec_zeros <= prec_zeros;
            if (r_neg) begin
                r_sign_len <= 1'b1;
                r_sign_ch  <= CH_MINUS;
            end else if (r_force_plus) begin
                r_sign_len <= 1'b1;
                r_sign_ch  <= CH_PLUS;
            end else if (r_space_sign) begin
                r_sign_len <= 1'b1;
                r_sign_ch  <= CH_SPACE;
            end else begin
                r_sign_len <= 1'b0;
                r_sign_ch  <= CH_SPACE;
            end
        end
        if (r_state == ST_LAYOUT) begin
            r_b_lead <= b_lead;
            r_b_sign <= b_sign;
            r_b_zero <= b_zero;
            r_b_dig  <= b_dig;
            r_total  <= total;
            r_pos    <= '0;
            r_dig    <= DIG_IDX_W'(r_ndig - 1'b1);
        end
        if (advance) begin
            r_o_char <= cur_char;
            r_o_last <= is_last;
            r_pos    <= r_pos + 1'b1;
            if (is_digit) begin
                r_dig <= r_dig - 1'b1;
            end
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_last_char = r_o_last;

    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CONV) && bcd_busy)
        else $error("accepted item did not start conversion");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_total != '0) && (r_pos < r_total))
        else $error("emit position outside the text");

    a_digit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && is_digit |-> (t_len'(r_dig) < t_len'(r_ndig)))
        else $error("digit index beyond digit count");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_last |=> (r_state == ST_IDLE) && o_valid && o_last_char)
        else $error("final character did not end the item");

endmodule

FILE: design/sdf_bcd.sv
// ----------------------------------------------------------------------------
// sdf_bcd
// Bit-serial binary to decimal converter. The magnitude is shifted in one bit
// per cycle, most significant first, through a shift-and-add-3 digit register.
// ----------------------------------------------------------------------------
module sdf_bcd import sdf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [VAL_W-1:0] i_mag,
    output logic             o_busy,
    output t_bcd             o_bcd
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [VAL_W-1:0]  r_bin;
    t_bcd              r_bcd;

    t_bcd              adj;
    logic [BCD_W-1:0]  adj_flat;

    // Digits of five or more are corrected before each doubling.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= DIG_W'(5)) ? (r_bcd[i] + DIG_W'(3)) : r_bcd[i];
        end
        adj_flat = adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(VAL_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
            r_bcd <= {adj_flat[BCD_W-2:0], r_bin[VAL_W-1]};
        end
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_busy && (r_cnt == STEP_W'(VAL_W)))
        else $error("converter did not start on load");

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("converter busy with zero step count");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_load && (r_cnt == STEP_W'(1)) |=> !r_busy)
        else $error("converter did not finish after its last step");

endmodule

FILE: tb/sdf_text_checker.sv
// ----------------------------------------------------------------------------
// sdf_text_checker
// Watches both channels and the register port of the signed decimal
// formatter. It keeps a shadow copy of the registers, predicts the text of
// every accepted value, and compares each character taken from the block
// with the oldest expected one.
// ----------------------------------------------------------------------------
module sdf_text_checker import sdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Value channel, as seen at the block's input.
    input  logic                  i_value_valid,
    input  logic [VAL_W-1:0]      i_value,
    input  logic                  i_value_stall,
    // Character channel, as seen at the block's output.
    input  logic                  i_char_valid,
    input  logic [CHAR_W-1:0]     i_out_char,
    input  logic                  i_last_char,
    input  logic                  i_char_stall,
    // Register writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Results handed to the testbench top.
    output int                    o_mismatches,
    output int                    o_pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    t_text_char text_expected[$];
    int unsigned chars_left;

    // Shadow registers.
    logic [CFG_DATA_W-1:0] cfg_width;
    logic [CFG_DATA_W-1:0] cfg_prec;
    logic                  cfg_prec_given;
    logic                  cfg_left;
    logic                  cfg_zero_fill;
    logic                  cfg_plus;
    logic                  cfg_space;

    function automatic void add_run(input logic [CHAR_W-1:0] ch, input int unsigned count);
        t_text_char tc;
        repeat (count) begin
            chars_left--;
            tc.ch   = ch;
            tc.last = (chars_left == 0);
            text_expected.push_back(tc);
        end
    endfunction

    // Lays out [spaces][sign][fill zeros][precision zeros][digits][spaces].
    function automatic void format_decimal(input logic [VAL_W-1:0] raw);
        logic              negative;
        logic [VAL_W-1:0]  magnitude;
        int unsigned       width_eff, prec_eff, ndig, prec_zeros, body, pad;
        logic [DIG_W-1:0]  digits [NDIG];
        logic [CHAR_W-1:0] sign_ch;
        bit                has_sign;
        bit                zero_pad;
        negative  = raw[VAL_W-1];
        magnitude = negative ? (~raw + 1'b1) : raw;
        width_eff = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        prec_eff  = (cfg_prec > MAX_PRECISION) ? MAX_PRECISION : cfg_prec;
        ndig      = 0;
        // A zero with a given precision of zero has no digits at all.
        if (!(cfg_prec_given && prec_eff == 0 && magnitude == '0)) begin
            do begin
                digits[ndig] = DIG_W'(magnitude % 10);
                ndig++;
                magnitude = magnitude / 10;
            end while (magnitude != '0);
        end
        has_sign = 1'b1;
        if (negative) begin
            sign_ch = CH_MINUS;
        end else if (cfg_plus) begin
            sign_ch = CH_PLUS;
        end else if (cfg_space) begin
            sign_ch = CH_SPACE;
        end else begin
            sign_ch  = CH_SPACE;
            has_sign = 1'b0;
        end
        prec_zeros = (cfg_prec_given && prec_eff > ndig) ? prec_eff - ndig : 0;
        body       = has_sign + prec_zeros + ndig;
        pad        = (width_eff > body) ? width_eff - body : 0;
        zero_pad   = cfg_zero_fill && !cfg_left && !cfg_prec_given;
        chars_left = pad + body;
        if (!cfg_left && !zero_pad) add_run(CH_SPACE, pad);
        if (has_sign) add_run(sign_ch, 1);
        if (zero_pad) add_run(CH_ZERO, pad);
        add_run(CH_ZERO, prec_zeros);
        for (int i = ndig; i > 0; i--) add_run(CH_ZERO + digits[i-1], 1);
        if (cfg_left) add_run(CH_SPACE, pad);
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            cfg_width      = '0;
            cfg_prec       = '0;
            cfg_prec_given = 1'b0;
            cfg_left       = 1'b0;
            cfg_zero_fill  = 1'b0;
            cfg_plus       = 1'b0;
            cfg_space      = 1'b0;
            text_expected.delete();
            o_mismatches   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIELD_WIDTH:     cfg_width      = i_cfg_data;
                    REG_MIN_DIGITS:      cfg_prec       = i_cfg_data;
                    REG_PRECISION_GIVEN: cfg_prec_given = i_cfg_data[0];
                    REG_LEFT_JUSTIFY:    cfg_left       = i_cfg_data[0];
                    REG_ZERO_FILL:       cfg_zero_fill  = i_cfg_data[0];
                    REG_FORCE_PLUS:      cfg_plus       = i_cfg_data[0];
                    REG_SPACE_SIGN:      cfg_space      = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_value_valid && !i_value_stall) format_decimal(i_value);
            if (i_char_valid && !i_char_stall) begin
                if (text_expected.size() == 0) begin
                    $display("%0t: unexpected character: expected none, got 0x%02h last %0b",
                             $time, i_out_char, i_last_char);
                    o_mismatches++;
                end else begin
                    want = text_expected.pop_front();
                    if (i_out_char !== want.ch) begin
                        $display("%0t: character mismatch: expected 0x%02h, got 0x%02h",
                                 $time, want.ch, i_out_char);
                        o_mismatches++;
                    end
                    if (i_last_char !== want.last) begin
                        $display("%0t: last flag mismatch: expected %0b, got %0b",
                                 $time, want.last, i_last_char);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending_chars = text_expected.size();
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the signed decimal formatter. A short directed
// pass covers the extreme values and each formatting rule, then random
// register settings are each followed by a burst of random values, with
// random idling on both channels, one long output hold-off and one full
// drain. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb import sdf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Cycles to wait after the last expected character before touching the
    // registers. A value with empty text leaves no character behind, but the
    // block still spends the conversion and layout time on it.
    localparam int SETTLE_CYCLES = 60;
    // Length of the long output hold-off, in cycles.
    localparam int HOLD_CYCLES   = 400;
    // Cycles with no activity at all before the run is declared hung. The
    // worst quiet stretch is the hold-off, so this leaves ample margin.
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 14;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic [VAL_W-1:0]      i_value;
    logic                  o_stall;
    logic                  o_valid;
    logic [CHAR_W-1:0]     o_out_char;
    logic                  o_last_char;
    logic                  i_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int mismatches;
    int pending_chars;
    int idle_cycles;

    // Requests from the stimulus to the output side, set just after a rising
    // edge and picked up by the output process at the following falling edge.
    bit hold_request;
    bit rx_quiet;
    // Sender idling is switched off per phase and for the final phase.
    bit tx_quiet;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_decimal_formatter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    sdf_text_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value_valid   (i_valid),
        .i_value         (i_value),
        .i_value_stall   (o_stall),
        .i_char_valid    (o_valid),
        .i_out_char      (o_out_char),
        .i_last_char     (o_last_char),
        .i_char_stall    (i_stall),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending_chars (pending_chars)
    );

    // Watchdog: any accepted item, taken character or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Output side. Every falling edge gets exactly one assignment to i_stall.
    // A hold-off request overrides everything else, then rx_quiet holds it ready;
    // otherwise the line alternates between random bursts of stall and readiness.
    initial begin
        int  hold_left;
        int  burst_left;
        bit  burst_stall;
        hold_left   = 0;
        burst_left  = 0;
        burst_stall = 1'b0;
        i_stall     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    // Roughly one burst in three stalls, so ready stretches
                    // also get long enough to stream whole texts.
                    burst_stall = ($urandom_range(0, 2) == 0);
                    burst_left  = $urandom_range(1, 18);
                end
                i_stall <= burst_stall;
                burst_left--;
            end
        end
    end

    // Offers one value and returns at the rising edge where it was taken.
    // The payload stays put while the block stalls.
    task automatic send_value(input logic [VAL_W-1:0] v);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender idles for a random burst, scrambling the payload meanwhile.
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 18);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_value <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // Stops offering, waits for every expected character, then lets the
    // block finish any value whose text was empty.
    task automatic let_block_settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_chars != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // One-bit registers get random upper data bits, which must be ignored.
    function automatic logic [CFG_DATA_W-1:0] flag_data(input bit flag);
        logic [CFG_DATA_W-1:0] d;
        d    = CFG_DATA_W'($urandom);
        d[0] = flag;
        return d;
    endfunction

    // Writes every register; the block must be idle. Ends just after the
    // rising edge that follows the last write.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] prec,
                                input bit prec_given, input bit left,
                                input bit zero_fill, input bit plus,
                                input bit space);
        write_reg(REG_FIELD_WIDTH,     width);
        write_reg(REG_MIN_DIGITS,      prec);
        write_reg(REG_PRECISION_GIVEN, flag_data(prec_given));
        write_reg(REG_LEFT_JUSTIFY,    flag_data(left));
        write_reg(REG_ZERO_FILL,       flag_data(zero_fill));
        write_reg(REG_FORCE_PLUS,      flag_data(plus));
        write_reg(REG_SPACE_SIGN,      flag_data(space));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Field width or precision: mostly small, with the saturating extremes
    // and oversized codes mixed in.
    function automatic logic [CFG_DATA_W-1:0] pick_size(input int limit);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(limit);
            2:       return '1;
            3:       return CFG_DATA_W'($urandom_range(limit + 1, 63));
            default: return CFG_DATA_W'($urandom_range(0, 14));
        endcase
    endfunction

    // Values lean toward the cases that exercise digit counts and signs.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 6))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 40) - 20;
            3: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p - $urandom_range(0, 1);
                if ($urandom_range(0, 1)) v = -v;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [VAL_W-1:0] plain_values [9];
        int n_items;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        hold_request = 1'b0;
        rx_quiet     = 1'b0;
        tx_quiet     = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset settings: plain text of the extreme
        // values, one and two digit values, and the most negative value.
        plain_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'd10, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'd1000000000, 32'h5A5A_5A5A};
        foreach (plain_values[i]) send_value(plain_values[i]);

        // Given precision of zero: a zero prints nothing and gives no item.
        let_block_settle();
        program_regs(6'd0, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_value(32'd0);
        send_value(32'd3);

        // Oversized width saturates; zero fill goes after the sign.
        let_block_settle();
        program_regs(6'd63, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_value(-32'd5);
        send_value(32'd0);
        send_value(32'h7FFF_FFFF);

        // Oversized precision saturates, left justify, and a given precision
        // turns zero fill off.
        let_block_settle();
        program_regs(6'd48, 6'd63, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        send_value(32'h8000_0000);
        send_value(32'd0);

        // Precision zeros count toward the width; space sign on non-negative.
        let_block_settle();
        program_regs(6'd12, 6'd5, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        send_value(32'd42);
        send_value(-32'd42);

        // Precision not given: the digit count is ignored; zero fill counts
        // the minus sign.
        let_block_settle();
        program_regs(6'd8, 6'd3, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        send_value(32'd0);
        send_value(-32'd7);

        // Plus wins over space; a zero with no digits leaves just the sign.
        let_block_settle();
        program_regs(6'd1, 6'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        send_value(32'd0);

        // Random part: a fresh register setting per phase, then a burst of
        // values. The last phase runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            let_block_settle();
            program_regs(pick_size(MAX_WIDTH), pick_size(MAX_PRECISION),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0,
                         1'($urandom_range(0, 1)));
            tx_quiet = (phase % 4 == 2) || (phase == RANDOM_PHASES - 1);
            rx_quiet = (phase == RANDOM_PHASES - 1);
            n_items  = $urandom_range(20, 26);
            for (int k = 0; k < n_items; k++) begin
                if (!tx_quiet && $urandom_range(0, 3) == 0) sender_gap();
                send_value(pick_value());
                // Long output hold-off while the sender keeps offering, so
                // the block fills up and stalls its input.
                if (phase == 5 && k == 2) hold_request = 1'b1;
                // Sender pause until every expected character has come.
                if (phase == 8 && k == 10) let_block_settle();
            end
        end

        // Drain, then give the block time to show any stray output.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_chars != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && pending_chars == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
